FILE: rtl/core/mp4stw_pkg.sv
// Package: shared types, codes and defaults of the MP4 sample table walker.
`timescale 1ns / 1ps
`default_nettype none
package mp4stw_pkg;

    localparam int SIZE_DEPTH_DEF  = 4096;
    localparam int MAP_DEPTH_DEF   = 1024;
    localparam int CHUNK_DEPTH_DEF = 4096;

    localparam logic [31:0] ALL_ONES32  = 32'hffff_ffff;
    localparam logic [7:0]  NIBBLE_MASK = 8'h0f;

    localparam logic [2:0] OP_LOAD_SIZE  = 3'd0;
    localparam logic [2:0] OP_LOAD_MAP   = 3'd1;
    localparam logic [2:0] OP_LOAD_CHUNK = 3'd2;
    localparam logic [2:0] OP_START      = 3'd3;
    localparam logic [2:0] OP_FETCH      = 3'd4;

    localparam logic [1:0] ST_SAMPLE = 2'd0;
    localparam logic [1:0] ST_EOS    = 2'd1;
    localparam logic [1:0] ST_ACK    = 2'd2;

    localparam logic [2:0] MODE_CONST = 3'd0;
    localparam logic [2:0] MODE_4BIT  = 3'd1;
    localparam logic [2:0] MODE_8BIT  = 3'd2;
    localparam logic [2:0] MODE_16BIT = 3'd3;

    localparam logic [2:0] CFG_SAMPLE_TOTAL  = 3'd0;
    localparam logic [2:0] CFG_SIZE_MODE     = 3'd1;
    localparam logic [2:0] CFG_CONST_SIZE    = 3'd2;
    localparam logic [2:0] CFG_MAP_ENTRIES   = 3'd3;
    localparam logic [2:0] CFG_CHUNK_ENTRIES = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] entry_index;
        logic [31:0] size_word;
        logic [31:0] first_chunk;
        logic [31:0] samples_in_chunk;
        logic [31:0] description_in;
        logic [63:0] chunk_offset_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] sample_offset;
        logic [31:0] sample_size;
        logic [31:0] description_out;
    } t_result;

    typedef struct packed {
        logic [31:0] first_chunk;
        logic [31:0] sample_count;
        logic [31:0] description;
    } t_map_entry;

endpackage
`default_nettype wire

FILE: rtl/core/mp4_sample_table_walker_unit.sv
// Top level: MP4 sample table walker with size, chunk map and chunk offset memories.
//
// Usage: a command is taken when start is high and busy is low. Loads (size,
// chunk map, chunk offset) write one memory entry if the index is in range
// and answer with an ack in the next cycle; busy stays low. Start sums the
// chunk map counts, one entry per cycle, may append one made-up entry, then
// loads sample 0 and answers with an ack at the end. Fetch answers in the
// cycle after it is taken with the current sample (or end of stream) and
// then keeps busy high while it reads the size and chunk map memories
// together and then the offset memory for the next sample (busy stays low
// once the walk ends). Unknown ops give no answer. Each answer sits on
// o_result for one cycle with o_strobe high; the receiver cannot stall.
// Configuration writes on the cfg port take effect at once and must be made
// by the user only while the block is idle; the block does not enforce it.
// Reset clears the walk state; memory contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module mp4_sample_table_walker_unit
    import mp4stw_pkg::*;
#(
    parameter int SIZE_DEPTH  = SIZE_DEPTH_DEF,
    parameter int MAP_DEPTH   = MAP_DEPTH_DEF,
    parameter int CHUNK_DEPTH = CHUNK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_cmd        i_cmd,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    localparam int SA_W = $clog2(SIZE_DEPTH);
    localparam int CA_W = $clog2(CHUNK_DEPTH);
    localparam int MA_W = $clog2(MAP_DEPTH + 1);
    localparam int MU_W = $clog2(MAP_DEPTH + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_FAB  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_OFF  = 3'd5;

    logic [31:0] size_mem [SIZE_DEPTH];
    t_map_entry  map_mem  [MAP_DEPTH + 1];
    logic [63:0] off_mem  [CHUNK_DEPTH];

    logic [31:0] r_sample_total, r_const_size;
    logic [2:0]  r_size_mode;
    logic [10:0] r_map_entries;
    logic [12:0] r_chunk_entries;

    logic [2:0]       r_state;
    logic             r_is_start, r_take_left, r_rd_v, r_size_oob;
    logic [MU_W-1:0]  r_n, r_cnt, r_map_used;
    logic [31:0]      r_total;
    t_map_entry       r_last;
    logic [31:0]      r_cur, r_left, r_prev, r_held_size, r_held_desc;
    logic [MA_W-1:0]  r_pos;
    logic [63:0]      r_running, r_held_off;
    logic [31:0]      r_size_q;
    t_map_entry       r_map_q;
    logic [63:0]      r_off_q;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // memory ports
    logic            size_we, map_we, off_we, map_re;
    logic [MA_W-1:0] map_wa, map_ra;
    t_map_entry      map_wd;
    logic [31:0]     w_sidx;
    logic [31:0]     n_left, w_chunk_m1, w_lim, w_size, w_word;
    logic [31:0]     w_n_clamp;

    assign size_we = accept && (i_cmd.op == OP_LOAD_SIZE)
                     && ({20'd0, i_cmd.entry_index} < 32'(SIZE_DEPTH));
    assign off_we  = accept && (i_cmd.op == OP_LOAD_CHUNK)
                     && ({20'd0, i_cmd.entry_index} < 32'(CHUNK_DEPTH));
    assign w_sidx  = (r_size_mode == MODE_4BIT) ? {1'b0, r_cur[31:1]} : r_cur;

    always_comb begin
        map_we = 1'b0;
        map_wa = MA_W'(i_cmd.entry_index);
        map_wd = '{i_cmd.first_chunk, i_cmd.samples_in_chunk, i_cmd.description_in};
        if (r_state == S_FAB) begin
            map_we = (r_total < r_sample_total);
            map_wa = r_n[MA_W-1:0];
            map_wd = '{r_last.first_chunk + 32'd1, r_sample_total - r_total,
                       r_last.description};
        end else if (accept && (i_cmd.op == OP_LOAD_MAP)
                     && ({20'd0, i_cmd.entry_index} < 32'(MAP_DEPTH))) begin
            map_we = 1'b1;
        end
    end

    assign map_re = (r_state == S_SUM) || (r_state == S_RD);
    assign map_ra = (r_state == S_SUM) ? r_cnt[MA_W-1:0] : r_pos;

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            size_mem[SA_W'(i_cmd.entry_index)] <= i_cmd.size_word;
        end
        if (r_state == S_RD) begin
            r_size_q <= size_mem[w_sidx[SA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= map_mem[map_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            off_mem[CA_W'(i_cmd.entry_index)] <= i_cmd.chunk_offset_in;
        end
        if (r_state == S_EVAL) begin
            r_off_q <= off_mem[w_chunk_m1[CA_W-1:0]];
        end
    end

    // evaluation of the loaded entry
    always_comb begin
        n_left     = r_take_left ? r_map_q.sample_count : r_left;
        w_chunk_m1 = r_map_q.first_chunk - 32'd1;
        w_lim      = ({19'd0, r_chunk_entries} > 32'(CHUNK_DEPTH)) ?
                     32'(CHUNK_DEPTH) : {19'd0, r_chunk_entries};
        w_word     = r_size_oob ? 32'd0 : r_size_q;
        case (r_size_mode)
            MODE_CONST: w_size = r_const_size;
            MODE_4BIT:  w_size = r_cur[0] ? {28'd0, w_word[3:0] & NIBBLE_MASK[3:0]}
                                          : {28'd0, w_word[7:4]};
            MODE_8BIT:  w_size = {24'd0, w_word[7:0]};
            MODE_16BIT: w_size = {16'd0, w_word[15:0]};
            default:    w_size = w_word;
        endcase
        w_n_clamp = ({21'd0, r_map_entries} > 32'(MAP_DEPTH)) ?
                    32'(MAP_DEPTH) : {21'd0, r_map_entries};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_total  <= '0;
            r_size_mode     <= '0;
            r_const_size    <= '0;
            r_map_entries   <= '0;
            r_chunk_entries <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_TOTAL:  r_sample_total  <= i_cfg_data;
                CFG_SIZE_MODE:     r_size_mode     <= i_cfg_data[2:0];
                CFG_CONST_SIZE:    r_const_size    <= i_cfg_data;
                CFG_MAP_ENTRIES:   r_map_entries   <= i_cfg_data[10:0];
                CFG_CHUNK_ENTRIES: r_chunk_entries <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_strobe    <= 1'b0;
            o_result    <= '0;
            r_is_start  <= 1'b0;
            r_take_left <= 1'b0;
            r_rd_v      <= 1'b0;
            r_size_oob  <= 1'b0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_map_used  <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_cur       <= '0;
            r_left      <= '0;
            r_prev      <= ALL_ONES32;
            r_held_size <= '0;
            r_held_desc <= '0;
            r_pos       <= '0;
            r_running   <= '0;
            r_held_off  <= '0;
        end else begin
            o_strobe <= 1'b0;
            o_result <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd.op)
                            OP_LOAD_SIZE, OP_LOAD_MAP, OP_LOAD_CHUNK: begin
                                o_strobe        <= 1'b1;
                                o_result.status <= ST_ACK;
                            end
                            OP_START: begin
                                r_pos       <= '0;
                                r_prev      <= ALL_ONES32;
                                r_running   <= '0;
                                r_held_size <= '0;
                                r_held_desc <= '0;
                                r_held_off  <= '0;
                                r_cur       <= '0;
                                r_is_start  <= 1'b1;
                                r_take_left <= 1'b1;
                                if (w_n_clamp == 32'd0) begin
                                    r_map_used      <= '0;
                                    r_left          <= '0;
                                    r_cur           <= r_sample_total;
                                    o_strobe        <= 1'b1;
                                    o_result.status <= ST_ACK;
                                end else begin
                                    r_n     <= MU_W'(w_n_clamp);
                                    r_cnt   <= '0;
                                    r_total <= '0;
                                    r_rd_v  <= 1'b0;
                                    r_state <= S_SUM;
                                end
                            end
                            OP_FETCH: begin
                                o_strobe <= 1'b1;
                                if (r_map_used == '0 || r_cur >= r_sample_total) begin
                                    o_result.status <= ST_EOS;
                                end else begin
                                    o_result <= '{ST_SAMPLE, r_held_off, r_held_size,
                                                  r_held_desc};
                                    r_is_start <= 1'b0;
                                    r_running  <= r_running + {32'd0, r_held_size};
                                    r_cur      <= r_cur + 32'd1;
                                    r_left     <= r_left - 32'd1;
                                    r_take_left <= 1'b0;
                                    if (r_left == 32'd1) begin
                                        if (MU_W'(r_pos) + MU_W'(1) >= r_map_used) begin
                                            r_cur <= r_sample_total;
                                        end else begin
                                            r_pos       <= r_pos + MA_W'(1);
                                            r_take_left <= 1'b1;
                                            r_state     <= S_RD;
                                        end
                                    end else begin
                                        r_state <= S_RD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    r_rd_v <= (r_cnt < r_n);
                    if (r_cnt < r_n) begin
                        r_cnt <= r_cnt + MU_W'(1);
                    end
                    if (r_rd_v) begin
                        r_total <= r_total + r_map_q.sample_count;
                        r_last  <= r_map_q;
                    end else if (r_cnt == r_n) begin
                        r_state <= S_FAB;
                    end
                end
                S_FAB: begin
                    r_map_used <= (r_total < r_sample_total) ? r_n + MU_W'(1) : r_n;
                    r_state    <= S_RD;
                end
                S_RD: begin
                    r_size_oob <= (w_sidx >= 32'(SIZE_DEPTH));
                    r_state    <= S_EVAL;
                end
                S_EVAL: begin
                    r_left  <= n_left;
                    r_state <= S_IDLE;
                    if (r_cur < r_sample_total) begin
                        r_held_size <= w_size;
                        if (n_left == 32'd0) begin
                            r_cur <= r_sample_total;
                        end else begin
                            r_held_desc <= r_map_q.description;
                            if (r_map_q.first_chunk == 32'd0) begin
                                r_cur <= r_sample_total;
                            end else if (w_chunk_m1 != r_prev) begin
                                r_prev <= w_chunk_m1;
                                if (w_chunk_m1 >= w_lim) begin
                                    r_cur <= r_sample_total;
                                end else begin
                                    r_state <= S_OFF;
                                end
                            end else begin
                                r_held_off <= r_running;
                            end
                        end
                    end
                    if (r_is_start) begin
                        o_strobe        <= (r_state == S_EVAL) && !(r_cur < r_sample_total
                                           && n_left != 32'd0 && r_map_q.first_chunk != 32'd0
                                           && w_chunk_m1 != r_prev && w_chunk_m1 < w_lim);
                        o_result.status <= ST_ACK;
                    end
                end
                S_OFF: begin
                    r_running  <= r_off_q;
                    r_held_off <= r_off_q;
                    r_state    <= S_IDLE;
                    if (r_is_start) begin
                        o_strobe        <= 1'b1;
                        o_result.status <= ST_ACK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/mp4stw_checker.sv
// Checker: port-level assertions for the sample table walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mp4stw_checker
    import mp4stw_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_cmd    i_cmd,
    input wire logic    o_strobe,
    input wire t_result o_result
);
    logic acc;
    assign acc = start && !busy;

    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_cmd.op == OP_LOAD_SIZE || i_cmd.op == OP_LOAD_MAP
                || i_cmd.op == OP_LOAD_CHUNK)
        |=> o_strobe && o_result.status == ST_ACK)
        else $error("load item not acknowledged");

    a_fetch_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_cmd.op == OP_FETCH
        |=> o_strobe && (o_result.status == ST_SAMPLE || o_result.status == ST_EOS))
        else $error("fetch item without sample or end of stream");

    a_unknown_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !(i_cmd.op == OP_LOAD_SIZE || i_cmd.op == OP_LOAD_MAP
                 || i_cmd.op == OP_LOAD_CHUNK || i_cmd.op == OP_START
                 || i_cmd.op == OP_FETCH)
        |=> !o_strobe)
        else $error("unknown op produced a result");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_SAMPLE
        |-> o_result.sample_offset == 64'd0 && o_result.sample_size == 32'd0
            && o_result.description_out == 32'd0)
        else $error("non-sample result carries payload");
endmodule

bind mp4_sample_table_walker_unit mp4stw_checker u_mp4stw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire
